>>> hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 32;
    localparam int PRIO_W      = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_APPEND  = 3'd0,
        KIND_PREPEND = 3'd1,
        KIND_REMOVE  = 3'd2,
        KIND_INSERT  = 3'd3,
        KIND_DELETE  = 3'd4,
        KIND_PEEK    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } fsm_state_t;

    // entry shift control for the store
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
    } store_ctl_t;

    typedef struct packed {
        logic less;
        logic match;
    } cmp_res_t;

endpackage

>>> hw/rtl/spq_cmp.sv
module spq_cmp (
    input  logic signed [spq_pkg::PRIO_W-1:0]    key_prio,
    input  logic        [spq_pkg::TAG_WIDTH-1:0] key_tag,
    input  logic signed [spq_pkg::PRIO_W-1:0]    ent_prio,
    input  logic        [spq_pkg::TAG_WIDTH-1:0] ent_tag,
    output spq_pkg::cmp_res_t                    res
);

    always_comb begin
        res.less  = key_prio < ent_prio;
        res.match = key_tag == ent_tag;
    end

endmodule

>>> hw/rtl/spq_store.sv
module spq_store (
    input  logic                                 aclk,
    input  spq_pkg::store_ctl_t                  ctl,
    input  logic        [spq_pkg::TAG_WIDTH-1:0] wr_tag,
    input  logic signed [spq_pkg::PRIO_W-1:0]    wr_prio,
    input  logic        [spq_pkg::IDX_W-1:0]     rd_idx,
    output logic        [spq_pkg::TAG_WIDTH-1:0] rd_tag,
    output logic signed [spq_pkg::PRIO_W-1:0]    rd_prio,
    output logic        [spq_pkg::TAG_WIDTH-1:0] head_tag
);

    localparam int D = spq_pkg::QUEUE_DEPTH;

    logic        [spq_pkg::TAG_WIDTH-1:0] tag_reg  [D];
    logic signed [spq_pkg::PRIO_W-1:0]    prio_reg [D];

    assign rd_tag   = tag_reg[rd_idx];
    assign rd_prio  = prio_reg[rd_idx];
    assign head_tag = tag_reg[0];

    // each slot takes from its fixed neighbors: up on insert, down on remove
    for (genvar i = 0; i < D; i++) begin : g_slot
        logic        [spq_pkg::TAG_WIDTH-1:0] tag_next;
        logic signed [spq_pkg::PRIO_W-1:0]    prio_next;
        logic [spq_pkg::IDX_W-1:0] here;

        assign here = spq_pkg::IDX_W'(i);

        always_comb begin
            tag_next  = tag_reg[i];
            prio_next = prio_reg[i];
            if (ctl.ins) begin
                if (here == ctl.pos) begin
                    tag_next  = wr_tag;
                    prio_next = wr_prio;
                end else if (here > ctl.pos) begin
                    if (i > 0) begin
                        tag_next  = tag_reg[(i > 0) ? i - 1 : 0];
                        prio_next = prio_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end else if (ctl.rem) begin
                if (here >= ctl.pos && i < D - 1) begin
                    tag_next  = tag_reg[(i < D - 1) ? i + 1 : i];
                    prio_next = prio_reg[(i < D - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            tag_reg[i]  <= tag_next;
            prio_reg[i] <= prio_next;
        end
    end

endmodule

>>> hw/rtl/sorted_priority_queue_core.sv
// Sorted priority queue of up to 16 tagged entries. One request is taken at a
// time: s_ready is high only while the sequencer is idle. Peek, a full or empty
// queue and the unused kinds go from the start state straight to the finish
// state; append, prepend and remove pass through an update state between them.
// Sorted insert and delete-by-tag scan the held entries one per cycle through
// a single compare unit before the update; a delete that finds nothing goes
// from the scan straight to the finish state. Entries all shift together in
// the update state once the position is known. The sequencer is idle again as
// its result is registered, so the next request is accepted in the following
// cycle at the earliest. A finished result waits in the output register, and
// the next request may be accepted while it waits. A second result is held in
// the sequencer until the first is taken, and no request is accepted meanwhile.
module sorted_priority_queue_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_kind,
    input  logic [31:0]          s_item_tag,
    input  logic signed [63:0]   s_item_priority,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [31:0]          m_head_tag,
    output logic [4:0]           m_entry_count
);

    localparam int D     = spq_pkg::QUEUE_DEPTH;
    localparam int CNT_W = spq_pkg::CNT_W;
    localparam int IDX_W = spq_pkg::IDX_W;
    localparam int TW    = spq_pkg::TAG_WIDTH;

    spq_pkg::fsm_state_t state_reg, state_next;
    spq_pkg::kind_t      kind_reg, kind_next;
    spq_pkg::status_t    status_reg, status_next;
    logic [TW-1:0]       tag_reg, tag_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [31:0]         head_reg, head_next;

    logic                m_valid_reg, m_valid_next;
    spq_pkg::status_t    m_status_reg, m_status_next;
    logic [31:0]         m_head_reg, m_head_next;
    logic [4:0]          m_count_reg, m_count_next;

    spq_pkg::store_ctl_t ctl;
    spq_pkg::cmp_res_t   cmp;
    logic [TW-1:0]       rd_tag, first_tag;
    logic signed [spq_pkg::PRIO_W-1:0] rd_prio;
    logic                is_add;

    assign is_add = (kind_reg == spq_pkg::KIND_APPEND) ||
                    (kind_reg == spq_pkg::KIND_PREPEND) ||
                    (kind_reg == spq_pkg::KIND_INSERT);

    assign ctl.ins = (state_reg == spq_pkg::ST_UPDATE) && is_add;
    assign ctl.rem = (state_reg == spq_pkg::ST_UPDATE) && !is_add;
    assign ctl.pos = pos_reg;

    spq_store u_store (
        .aclk     (aclk),
        .ctl      (ctl),
        .wr_tag   (tag_reg),
        .wr_prio  ((kind_reg == spq_pkg::KIND_INSERT) ? prio_reg : '0),
        .rd_idx   (idx_reg[IDX_W-1:0]),
        .rd_tag   (rd_tag),
        .rd_prio  (rd_prio),
        .head_tag (first_tag)
    );

    spq_cmp u_cmp (
        .key_prio (prio_reg),
        .key_tag  (tag_reg),
        .ent_prio (rd_prio),
        .ent_tag  (rd_tag),
        .res      (cmp)
    );

    assign s_ready       = (state_reg == spq_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_head_tag    = m_head_reg;
    assign m_entry_count = m_count_reg;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        status_next   = status_reg;
        tag_next      = tag_reg;
        prio_next     = prio_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        head_next     = head_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_head_next   = m_head_reg;
        m_count_next  = m_count_reg;

        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next   = spq_pkg::kind_t'(s_kind);
                    tag_next    = TW'(s_item_tag);
                    prio_next   = s_item_priority;
                    idx_next    = '0;
                    status_next = spq_pkg::STAT_OK;
                    head_next   = '0;
                    state_next  = spq_pkg::ST_START;
                end
            end
            spq_pkg::ST_START: begin
                unique case (kind_reg) inside
                    spq_pkg::KIND_APPEND, spq_pkg::KIND_PREPEND,
                    spq_pkg::KIND_INSERT: begin
                        if (count_reg == CNT_W'(D)) begin
                            status_next = spq_pkg::STAT_FULL;
                            state_next  = spq_pkg::ST_FINISH;
                        end else if (kind_reg == spq_pkg::KIND_APPEND) begin
                            pos_next   = count_reg[IDX_W-1:0];
                            state_next = spq_pkg::ST_UPDATE;
                        end else if (kind_reg == spq_pkg::KIND_PREPEND) begin
                            pos_next   = '0;
                            state_next = spq_pkg::ST_UPDATE;
                        end else begin
                            state_next = spq_pkg::ST_SCAN;
                        end
                    end
                    spq_pkg::KIND_REMOVE, spq_pkg::KIND_PEEK: begin
                        if (count_reg == '0) begin
                            status_next = spq_pkg::STAT_EMPTY;
                            state_next  = spq_pkg::ST_FINISH;
                        end else begin
                            head_next = 32'(first_tag);
                            pos_next  = '0;
                            state_next = (kind_reg == spq_pkg::KIND_REMOVE) ?
                                         spq_pkg::ST_UPDATE : spq_pkg::ST_FINISH;
                        end
                    end
                    spq_pkg::KIND_DELETE: begin
                        if (count_reg == '0) begin
                            status_next = spq_pkg::STAT_EMPTY;
                            state_next  = spq_pkg::ST_FINISH;
                        end else begin
                            state_next = spq_pkg::ST_SCAN;
                        end
                    end
                    default: state_next = spq_pkg::ST_FINISH;
                endcase
            end
            spq_pkg::ST_SCAN: begin
                if (idx_reg == count_reg) begin
                    // ran off the tail: insert goes last, delete missed
                    if (kind_reg == spq_pkg::KIND_INSERT) begin
                        pos_next   = idx_reg[IDX_W-1:0];
                        state_next = spq_pkg::ST_UPDATE;
                    end else begin
                        status_next = spq_pkg::STAT_NOT_FOUND;
                        state_next  = spq_pkg::ST_FINISH;
                    end
                end else if ((kind_reg == spq_pkg::KIND_INSERT) ? cmp.less : cmp.match) begin
                    pos_next   = idx_reg[IDX_W-1:0];
                    state_next = spq_pkg::ST_UPDATE;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            spq_pkg::ST_UPDATE: begin
                count_next = is_add ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
                state_next = spq_pkg::ST_FINISH;
            end
            spq_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_head_next   = head_reg;
                    m_count_next  = 5'(count_reg);
                    state_next    = spq_pkg::ST_IDLE;
                end
            end
            default: state_next = spq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spq_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        tag_reg      <= tag_next;
        prio_reg     <= prio_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        head_reg     <= head_next;
        m_status_reg <= m_status_next;
        m_head_reg   <= m_head_next;
        m_count_reg  <= m_count_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(D))
        else $error("entry count above depth");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == spq_pkg::ST_SCAN |-> idx_reg <= count_reg)
        else $error("scan index past tail");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rem |-> count_reg != '0)
        else $error("remove on empty queue");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // kinds the block treats as no-ops
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_GAP     = 20;
    localparam int DRAIN_WAIT  = 30;

    localparam logic signed [63:0] PRIO_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] PRIO_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        spq_pkg::status_t status;
        logic [31:0]      head_tag;
        logic [4:0]       count;
    } qresult_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] tag;
        logic [63:0] prio;
        logic [4:0]  reps;
        logic        typed;
        qresult_t    want;
    } plan_row_t;

    localparam int PLAN_ROWS = 22;

    plan_row_t dir_plan [PLAN_ROWS] = '{
        '{spq_pkg::KIND_PEEK,    32'h0,         64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_EMPTY, 32'h0, 5'd0}},
        '{spq_pkg::KIND_REMOVE,  32'h0,         64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_EMPTY, 32'h0, 5'd0}},
        '{spq_pkg::KIND_DELETE,  32'h5,         64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_EMPTY, 32'h0, 5'd0}},
        '{KIND_SPARE6,           32'h1,         64'h1,    5'd1,  1'b1,
          '{spq_pkg::STAT_OK, 32'h0, 5'd0}},
        '{KIND_SPARE7,           32'hffff_ffff, '1,       5'd1,  1'b1,
          '{spq_pkg::STAT_OK, 32'h0, 5'd0}},
        '{spq_pkg::KIND_APPEND,  32'hffff_ffff, 64'h0123_4567_89ab_cdef, 5'd1, 1'b1,
          '{spq_pkg::STAT_OK, 32'h0, 5'd1}},
        // prepend ignores the priority it is given
        '{spq_pkg::KIND_PREPEND, 32'h0,         PRIO_MAX, 5'd1,  1'b1,
          '{spq_pkg::STAT_OK, 32'h0, 5'd2}},
        '{spq_pkg::KIND_INSERT,  32'h0000_a5a5, PRIO_MAX, 5'd1,  1'b1,
          '{spq_pkg::STAT_OK, 32'h0, 5'd3}},
        '{spq_pkg::KIND_INSERT,  32'h5a5a_0000, PRIO_MIN, 5'd1,  1'b1,
          '{spq_pkg::STAT_OK, 32'h0, 5'd4}},
        // equal priority lands behind the existing zero-priority entries
        '{spq_pkg::KIND_INSERT,  32'h0000_00c3, 64'h0,    5'd1,  1'b0, '0},
        '{spq_pkg::KIND_INSERT,  32'h0000_00d4, '1,       5'd1,  1'b0, '0},
        '{spq_pkg::KIND_PEEK,    32'h0,         64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_OK, 32'h5a5a_0000, 5'd6}},
        '{spq_pkg::KIND_DELETE,  32'h1234_5678, 64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_NOT_FOUND, 32'h0, 5'd6}},
        '{spq_pkg::KIND_DELETE,  32'h0000_00c3, 64'h0,    5'd1,  1'b0, '0},
        '{spq_pkg::KIND_REMOVE,  32'h0,         64'h0,    5'd1,  1'b0, '0},
        '{spq_pkg::KIND_APPEND,  32'h0000_0100, 64'h0,    5'd12, 1'b0, '0},
        '{spq_pkg::KIND_APPEND,  32'h0000_0200, 64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_FULL, 32'h0, 5'd16}},
        '{spq_pkg::KIND_PREPEND, 32'h0000_0300, 64'h0,    5'd1,  1'b1,
          '{spq_pkg::STAT_FULL, 32'h0, 5'd16}},
        '{spq_pkg::KIND_INSERT,  32'h0000_0400, PRIO_MIN, 5'd1,  1'b1,
          '{spq_pkg::STAT_FULL, 32'h0, 5'd16}},
        '{spq_pkg::KIND_DELETE,  32'hffff_ffff, 64'h0,    5'd1,  1'b0, '0},
        // duplicate tags: only the first one goes
        '{spq_pkg::KIND_DELETE,  32'h0000_0100, 64'h0,    5'd1,  1'b0, '0},
        '{spq_pkg::KIND_REMOVE,  32'h0,         64'h0,    5'd1,  1'b0, '0}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_kind;
    logic [31:0]        s_item_tag;
    logic signed [63:0] s_item_priority;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [31:0]        m_head_tag;
    logic [4:0]         m_entry_count;

    // shadow copy of the queue contents
    logic [spq_pkg::TAG_WIDTH-1:0] held_tags [spq_pkg::QUEUE_DEPTH];
    logic signed [63:0]            held_prios [spq_pkg::QUEUE_DEPTH];
    int                            held_n = 0;

    qresult_t pending_results [$];
    int       errors = 0;
    int       cycles = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       hold_left = 0;
    bit       hold_req = 1'b0;

    always #5 aclk = ~aclk;

    sorted_priority_queue_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_item_tag      (s_item_tag),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_head_tag      (m_head_tag),
        .m_entry_count   (m_entry_count)
    );

    function automatic void close_gap(int pos);
        int i;
        for (i = pos; i + 1 < held_n; i++) begin
            held_tags[i]  = held_tags[i + 1];
            held_prios[i] = held_prios[i + 1];
        end
        held_n--;
    endfunction

    function automatic qresult_t apply_queue_op(logic [2:0] kind, logic [31:0] tag,
                                                logic signed [63:0] prio);
        qresult_t r;
        int       pos;
        int       i;
        r = '{spq_pkg::STAT_OK, 32'h0, 5'd0};
        case (kind)
            spq_pkg::KIND_APPEND, spq_pkg::KIND_PREPEND, spq_pkg::KIND_INSERT: begin
                if (held_n >= spq_pkg::QUEUE_DEPTH) begin
                    r.status = spq_pkg::STAT_FULL;
                end else begin
                    pos = 0;
                    if (kind == spq_pkg::KIND_APPEND) begin
                        pos = held_n;
                    end else if (kind == spq_pkg::KIND_INSERT) begin
                        // first entry of strictly greater priority
                        while (pos < held_n && !(prio < held_prios[pos])) pos++;
                    end
                    for (i = held_n; i > pos; i--) begin
                        held_tags[i]  = held_tags[i - 1];
                        held_prios[i] = held_prios[i - 1];
                    end
                    held_tags[pos]  = tag;
                    held_prios[pos] = (kind == spq_pkg::KIND_INSERT) ? prio : 64'sd0;
                    held_n++;
                end
            end
            spq_pkg::KIND_REMOVE, spq_pkg::KIND_PEEK: begin
                if (held_n == 0) begin
                    r.status = spq_pkg::STAT_EMPTY;
                end else begin
                    r.head_tag = held_tags[0];
                    if (kind == spq_pkg::KIND_REMOVE) close_gap(0);
                end
            end
            spq_pkg::KIND_DELETE: begin
                if (held_n == 0) begin
                    r.status = spq_pkg::STAT_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < held_n && held_tags[pos] != tag) pos++;
                    if (pos < held_n) close_gap(pos);
                    else r.status = spq_pkg::STAT_NOT_FOUND;
                end
            end
            default: ;
        endcase
        r.count = 5'(held_n);
        return r;
    endfunction

    task automatic pick_random_op(input bit filling, output logic [2:0] kind,
                                  output logic [31:0] tag, output logic [63:0] prio);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 2) kind = roll[0] ? KIND_SPARE7 : KIND_SPARE6;
        else if (roll < (filling ? 27 : 10)) kind = spq_pkg::KIND_APPEND;
        else if (roll < (filling ? 42 : 16)) kind = spq_pkg::KIND_PREPEND;
        else if (roll < (filling ? 80 : 35)) kind = spq_pkg::KIND_INSERT;
        else if (roll < (filling ? 88 : 65)) kind = spq_pkg::KIND_REMOVE;
        else if (roll < (filling ? 96 : 90)) kind = spq_pkg::KIND_DELETE;
        else kind = spq_pkg::KIND_PEEK;

        // deletes mostly aim at a held tag; small tag pool makes duplicates
        if (kind == spq_pkg::KIND_DELETE && held_n > 0 && $urandom_range(0, 3) != 0)
            tag = held_tags[$urandom_range(0, held_n - 1)];
        else if ($urandom_range(0, 1) == 1)
            tag = $urandom_range(1, 12);
        else
            tag = $urandom;

        case ($urandom_range(0, 9))
            0: prio = PRIO_MIN;
            1: prio = PRIO_MAX;
            2, 3: prio = {$urandom, $urandom};
            4, 5: begin
                v = $urandom_range(0, 65535);
                prio = 64'(v - 32768);
            end
            default: begin
                v = $urandom_range(0, 6);
                prio = 64'(v - 3);
            end
        endcase
    endtask

    // present one request, wait for acceptance, record what should come back
    task automatic offer_request(input logic [2:0] kind, input logic [31:0] tag,
                                 input logic [63:0] prio, input bit typed,
                                 input qresult_t want);
        int       gap;
        qresult_t predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(1, 100) <= idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_item_tag      <= tag;
        s_item_priority <= prio;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_queue_op(kind, tag, prio);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic run_random(input int n);
        bit          filling;
        logic [2:0]  kind;
        logic [31:0] tag;
        logic [63:0] prio;
        filling = 1'b1;
        for (int k = 0; k < n; k++) begin
            // swing between filling up and draining so both ends get hit
            if (held_n == spq_pkg::QUEUE_DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
            else if (held_n == 0) filling = 1'b1;
            else if ($urandom_range(0, 29) == 0) filling = !filling;
            pick_random_op(filling, kind, tag, prio);
            offer_request(kind, tag, prio, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        qresult_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d head %h count %0d",
                         $time, m_status, m_head_tag, m_entry_count);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_head_tag !== want.head_tag ||
                    m_entry_count !== want.count) begin
                    errors++;
                    $display("%0t: mismatch: expected status %0d head %h count %0d,",
                             $time, want.status, want.head_tag, want.count,
                             " got status %0d head %h count %0d",
                             m_status, m_head_tag, m_entry_count);
                end
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = spq_pkg::KIND_PEEK;
        s_item_tag      = '0;
        s_item_priority = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_plan[r]) begin
            for (int k = 0; k < dir_plan[r].reps; k++)
                offer_request(dir_plan[r].kind, dir_plan[r].tag, dir_plan[r].prio,
                              dir_plan[r].typed, dir_plan[r].want);
        end

        run_random(220);
        idle_pct = 66;
        run_random(220);
        idle_pct  = 0;
        stall_pct = 66;
        run_random(220);
        idle_pct  = 8;
        stall_pct = 8;
        run_random(180);

        // let everything drain, then hold the result side off while requests pile up
        idle_pct  = 0;
        stall_pct = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        hold_req = 1'b1;
        run_random(40);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
